/* rtl/timestamp_stream_merger_macros.svh */
// Assertion macros shared by the timestamp stream merger RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef TIMESTAMP_STREAM_MERGER_MACROS_SVH
`define TIMESTAMP_STREAM_MERGER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tsm_pkg.sv */
// Types and constants of the timestamp stream merger.
// No dependencies; used by tsm_ctrl, tsm_dpath and the top level.
package tsm_pkg;

  localparam int FuncW    = 1;
  localparam int IdxW     = 3;
  localparam int SecW     = 32;
  localparam int NsW      = 30;
  localparam int TagW     = 16;
  localparam int OffNsW   = 31;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 32;

  localparam logic [FuncW-1:0] FuncLoad = 1'b0;
  localparam logic [FuncW-1:0] FuncTake = 1'b1;

  localparam logic [CfgIdxW-1:0] RegOffSec = 1'b0;
  localparam logic [CfgIdxW-1:0] RegOffNs  = 1'b1;

  localparam logic signed [31:0] NsPerSec = 32'sd1000000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_ADD,
    ST_LOAD_WR,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;    // take the input beat into the datapath
    logic add_en;     // offset add stage of a load
    logic write_en;   // normalize and write the slot of a load
    logic scan_step;  // read the slot at the scan pointer, advance
    logic finish;     // load the result register, release the winner
  } cmd_t;

  typedef struct packed {
    logic scan_last;  // scan pointer sits on the last slot
    logic out_free;   // result register can take a beat this cycle
  } sts_t;

endpackage

/* rtl/timestamp_stream_merger.sv */
// Top level of the timestamp stream merger: k-way merge of event heads.
// Depends on tsm_pkg, tsm_ctrl and tsm_dpath.
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------------
//   input   | in_valid_i / in_stall_o | func, stream_index, present, time, l1, tag
//   result  | out_valid_o/out_stall_i | found, chosen_stream, time, l1accept, tag
//   config  | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// A load beat goes through capture, offset add, then normalize and slot write.
// A take beat goes through capture, one slot read per cycle
//   through the single memory read port and comparator, one flush, result.
// Reset (async, active low) empties all slots and zeroes both offsets at once.
// A held result only delays the end of the next take; loads still run.
// Only a take produces a result beat; loads and exhausted marks produce none.

module timestamp_stream_merger #(
  parameter int NUM_STREAMS = 8,
  parameter int TAG_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [tsm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tsm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input beats
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tsm_pkg::FuncW-1:0]     func_i,
  input  logic [tsm_pkg::IdxW-1:0]      stream_index_i,
  input  logic                          present_i,
  input  logic [tsm_pkg::SecW-1:0]      time_seconds_i,
  input  logic [tsm_pkg::NsW-1:0]       time_nanoseconds_i,
  input  logic                          is_l1accept_i,
  input  logic [tsm_pkg::TagW-1:0]      head_tag_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic [tsm_pkg::IdxW-1:0]      chosen_stream_o,
  output logic [tsm_pkg::SecW-1:0]      out_seconds_o,
  output logic [tsm_pkg::NsW-1:0]       out_nanoseconds_o,
  output logic                          out_l1accept_o,
  output logic [tsm_pkg::TagW-1:0]      out_tag_o
);

  tsm_pkg::cmd_t cmd;
  tsm_pkg::sts_t sts;

  // sequencer: decides load vs take on accept, steps the scan
  tsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // offsets, slot memory, comparator and result register
  tsm_dpath #(
    .NUM_STREAMS (NUM_STREAMS),
    .TAG_BITS    (TAG_BITS)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .stream_index_i     (stream_index_i),
    .present_i          (present_i),
    .time_seconds_i     (time_seconds_i),
    .time_nanoseconds_i (time_nanoseconds_i),
    .is_l1accept_i      (is_l1accept_i),
    .head_tag_i         (head_tag_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .found_o            (found_o),
    .chosen_stream_o    (chosen_stream_o),
    .out_seconds_o      (out_seconds_o),
    .out_nanoseconds_o  (out_nanoseconds_o),
    .out_l1accept_o     (out_l1accept_o),
    .out_tag_o          (out_tag_o)
  );

endmodule

/* rtl/tsm_ctrl.sv */
// Sequencer of the timestamp stream merger: load and take state machine.
// Depends on tsm_pkg and timestamp_stream_merger_macros.svh.
`include "timestamp_stream_merger_macros.svh"

module tsm_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [tsm_pkg::FuncW-1:0]  func_i,
  input  tsm_pkg::sts_t              sts_i,
  output tsm_pkg::cmd_t              cmd_o
);

  tsm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tsm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (func_i == tsm_pkg::FuncTake) ? tsm_pkg::ST_SCAN : tsm_pkg::ST_LOAD_ADD;
        end
      end
      tsm_pkg::ST_LOAD_ADD: state_d = tsm_pkg::ST_LOAD_WR;
      tsm_pkg::ST_LOAD_WR:  state_d = tsm_pkg::ST_IDLE;
      tsm_pkg::ST_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = tsm_pkg::ST_FLUSH;
        end
      end
      tsm_pkg::ST_FLUSH: state_d = tsm_pkg::ST_DONE;
      tsm_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = tsm_pkg::ST_IDLE;
        end
      end
      default: state_d = tsm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      tsm_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      tsm_pkg::ST_LOAD_ADD: cmd_o.add_en    = 1'b1;
      tsm_pkg::ST_LOAD_WR:  cmd_o.write_en  = 1'b1;
      tsm_pkg::ST_SCAN:     cmd_o.scan_step = 1'b1;
      tsm_pkg::ST_FLUSH:    cmd_o.finish    = 1'b0;
      tsm_pkg::ST_DONE:     cmd_o.finish    = sts_i.out_free;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // one beat at a time: an accepted beat closes the input
  `TSM_ASSERT_NEXT(a_accept_closes, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input open after accept")
  // the input closes only because a beat was just taken
  `TSM_ASSERT_SAME(a_stall_after_beat, clk_i, rst_ni, $rose(in_stall_o), $past(in_valid_i), "stall rose without a beat")
  // a full scan always ends in the result state
  `TSM_ASSERT_NEXT(a_flush_to_done, clk_i, rst_ni, state_q == tsm_pkg::ST_FLUSH, state_q == tsm_pkg::ST_DONE, "flush did not reach done")

endmodule

/* rtl/tsm_dpath.sv */
// Datapath of the timestamp stream merger: offsets, slot memory, scan
// comparator and result register. Depends on tsm_pkg and the macro header.
`include "timestamp_stream_merger_macros.svh"

module tsm_dpath #(
  parameter int NUM_STREAMS = 8,
  parameter int TAG_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tsm_pkg::cmd_t                 cmd_i,
  output tsm_pkg::sts_t                 sts_o,
  input  logic                          cfg_we_i,
  input  logic [tsm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tsm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic [tsm_pkg::IdxW-1:0]      stream_index_i,
  input  logic                          present_i,
  input  logic [tsm_pkg::SecW-1:0]      time_seconds_i,
  input  logic [tsm_pkg::NsW-1:0]       time_nanoseconds_i,
  input  logic                          is_l1accept_i,
  input  logic [tsm_pkg::TagW-1:0]      head_tag_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic                          found_o,
  output logic [tsm_pkg::IdxW-1:0]      chosen_stream_o,
  output logic [tsm_pkg::SecW-1:0]      out_seconds_o,
  output logic [tsm_pkg::NsW-1:0]       out_nanoseconds_o,
  output logic                          out_l1accept_o,
  output logic [tsm_pkg::TagW-1:0]      out_tag_o
);

  localparam int SlotIdxW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int SlotTagW = (TAG_BITS < tsm_pkg::TagW) ? TAG_BITS : tsm_pkg::TagW;
  localparam logic [SlotIdxW-1:0] LastSlot = SlotIdxW'(NUM_STREAMS - 1);

  // offset registers
  logic [tsm_pkg::SecW-1:0]   off_sec_q;
  logic [tsm_pkg::OffNsW-1:0] off_ns_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_sec_q <= '0;
      off_ns_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tsm_pkg::RegOffSec: off_sec_q <= cfg_wdata_i;
        tsm_pkg::RegOffNs:  off_ns_q  <= cfg_wdata_i[tsm_pkg::OffNsW-1:0];
        default: ;
      endcase
    end
  end

  // captured beat
  logic [tsm_pkg::IdxW-1:0] in_idx_q;
  logic                     in_present_q;
  logic [tsm_pkg::SecW-1:0] in_sec_q;
  logic [tsm_pkg::NsW-1:0]  in_ns_q;
  logic                     in_l1_q;
  logic [SlotTagW-1:0]      in_tag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_idx_q     <= stream_index_i;
      in_present_q <= present_i;
      in_sec_q     <= time_seconds_i;
      in_ns_q      <= time_nanoseconds_i;
      in_l1_q      <= is_l1accept_i;
      in_tag_q     <= head_tag_i[SlotTagW-1:0];
    end
  end

  // load, first stage: raw sums
  logic [tsm_pkg::SecW-1:0] sum_sec_q;
  logic signed [31:0]       sum_ns_q;
  logic signed [31:0]       sum_ns_d;

  assign sum_ns_d = signed'({2'b00, in_ns_q}) + signed'({off_ns_q[tsm_pkg::OffNsW-1], off_ns_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_en) begin
      sum_sec_q <= in_sec_q + off_sec_q;
      sum_ns_q  <= sum_ns_d;
    end
  end

  // load, second stage: one carry or borrow, L1Accept heads pass raw
  logic [tsm_pkg::SecW-1:0] wr_sec;
  logic [tsm_pkg::NsW-1:0]  wr_ns;
  logic signed [31:0]       ns_fix;
  logic                     load_hit;
  logic [SlotIdxW-1:0]      wr_addr;
  logic                     mem_we;

  always_comb begin
    ns_fix = sum_ns_q;
    wr_sec = sum_sec_q;
    if (sum_ns_q < 0) begin
      ns_fix = sum_ns_q + tsm_pkg::NsPerSec;
      wr_sec = sum_sec_q - 32'd1;
    end else if (sum_ns_q >= tsm_pkg::NsPerSec) begin
      ns_fix = sum_ns_q - tsm_pkg::NsPerSec;
      wr_sec = sum_sec_q + 32'd1;
    end
    wr_ns = ns_fix[tsm_pkg::NsW-1:0];
    if (in_l1_q) begin
      wr_sec = in_sec_q;
      wr_ns  = in_ns_q;
    end
  end

  assign load_hit = 32'(in_idx_q) < NUM_STREAMS;
  assign wr_addr  = SlotIdxW'(in_idx_q);
  assign mem_we   = cmd_i.write_en && load_hit && in_present_q;

  // slot memory, one write and one registered read port
  logic [tsm_pkg::SecW-1:0] mem_sec [NUM_STREAMS];
  logic [tsm_pkg::NsW-1:0]  mem_ns  [NUM_STREAMS];
  logic                     mem_l1  [NUM_STREAMS];
  logic [SlotTagW-1:0]      mem_tag [NUM_STREAMS];

  logic [SlotIdxW-1:0]      scan_ptr_q;
  logic [tsm_pkg::SecW-1:0] rd_sec_q;
  logic [tsm_pkg::NsW-1:0]  rd_ns_q;
  logic                     rd_l1_q;
  logic [SlotTagW-1:0]      rd_tag_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_sec[wr_addr] <= wr_sec;
      mem_ns[wr_addr]  <= wr_ns;
      mem_l1[wr_addr]  <= in_l1_q;
      mem_tag[wr_addr] <= in_tag_q;
    end
    if (cmd_i.scan_step) begin
      rd_sec_q <= mem_sec[scan_ptr_q];
      rd_ns_q  <= mem_ns[scan_ptr_q];
      rd_l1_q  <= mem_l1[scan_ptr_q];
      rd_tag_q <= mem_tag[scan_ptr_q];
    end
  end

  // scan control and running best
  logic                     rd_vld_q;
  logic [SlotIdxW-1:0]      rd_idx_q;
  logic [NUM_STREAMS-1:0]   slot_vld_q;
  logic                     best_found_q;
  logic [SlotIdxW-1:0]      best_idx_q;
  logic [tsm_pkg::SecW-1:0] best_sec_q;
  logic [tsm_pkg::NsW-1:0]  best_ns_q;
  logic                     best_l1_q;
  logic [SlotTagW-1:0]      best_tag_q;
  logic                     cand_better;

  // strict less-than keeps the lower index on a tie
  assign cand_better = rd_vld_q && slot_vld_q[rd_idx_q]
                    && (!best_found_q || (rd_sec_q < best_sec_q)
                        || ((rd_sec_q == best_sec_q) && (rd_ns_q < best_ns_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_ptr_q   <= '0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      best_found_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_step;
      if (cmd_i.capture) begin
        scan_ptr_q   <= '0;
        best_found_q <= 1'b0;
      end else begin
        if (cmd_i.scan_step) begin
          scan_ptr_q <= scan_ptr_q + 1'b1;
          rd_idx_q   <= scan_ptr_q;
        end
        if (cand_better) begin
          best_found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cand_better) begin
      best_idx_q <= rd_idx_q;
      best_sec_q <= rd_sec_q;
      best_ns_q  <= rd_ns_q;
      best_l1_q  <= rd_l1_q;
      best_tag_q <= rd_tag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
    end else if (cmd_i.write_en && load_hit) begin
      slot_vld_q[wr_addr] <= in_present_q;
    end else if (cmd_i.finish && best_found_q) begin
      slot_vld_q[best_idx_q] <= 1'b0;
    end
  end

  // result register
  logic                     out_vld_q;
  logic                     out_found_q;
  logic [tsm_pkg::IdxW-1:0] out_idx_q;
  logic [tsm_pkg::SecW-1:0] out_sec_q;
  logic [tsm_pkg::NsW-1:0]  out_ns_q;
  logic                     out_l1_q;
  logic [tsm_pkg::TagW-1:0] out_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_found_q <= best_found_q;
      if (best_found_q) begin
        out_idx_q <= tsm_pkg::IdxW'(best_idx_q);
        out_sec_q <= best_sec_q;
        out_ns_q  <= best_ns_q;
        out_l1_q  <= best_l1_q;
        out_tag_q <= tsm_pkg::TagW'(best_tag_q);
      end else begin
        out_idx_q <= '0;
        out_sec_q <= '0;
        out_ns_q  <= '0;
        out_l1_q  <= 1'b0;
        out_tag_q <= '0;
      end
    end
  end

  assign sts_o.scan_last = (scan_ptr_q == LastSlot);
  assign sts_o.out_free  = !out_vld_q || !out_stall_i;

  assign out_valid_o       = out_vld_q;
  assign found_o           = out_found_q;
  assign chosen_stream_o   = out_idx_q;
  assign out_seconds_o     = out_sec_q;
  assign out_nanoseconds_o = out_ns_q;
  assign out_l1accept_o    = out_l1_q;
  assign out_tag_o         = out_tag_q;

  // a returned head leaves its slot empty
  `TSM_ASSERT_NEXT(a_winner_released, clk_i, rst_ni, cmd_i.finish && best_found_q, !slot_vld_q[$past(best_idx_q)], "winner slot still valid")
  // the scan never reads past the last slot
  `TSM_ASSERT_SAME(a_scan_in_range, clk_i, rst_ni, cmd_i.scan_step, 32'(scan_ptr_q) < NUM_STREAMS, "scan pointer out of range")

endmodule
